// ----- rtl/core/its_pkg.sv -----
// Shared types, codes and constants of the index table shuffler.
package its_pkg;

  localparam int CNT_W  = 11;
  localparam int FUNC_W = 2;
  localparam int SEED_W = 32;
  localparam int POS_W  = 10;
  localparam int ENT_W  = 10;
  localparam int PC_W   = 5;
  localparam int OP_W   = 5;
  localparam int COND_W = 4;

  localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'h00C0FFEE;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_SEED = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SHUFFLE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FILL      = 2'd3;

  // Datapath micro-operations.
  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_WAIT      = 5'd1;
  localparam logic [OP_W-1:0] OP_SEED_LD   = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_POS    = 5'd3;
  localparam logic [OP_W-1:0] OP_CAP_ENTRY = 5'd4;
  localparam logic [OP_W-1:0] OP_CLR_K     = 5'd5;
  localparam logic [OP_W-1:0] OP_FILL      = 5'd6;
  localparam logic [OP_W-1:0] OP_LD_I      = 5'd7;
  localparam logic [OP_W-1:0] OP_MUL       = 5'd8;
  localparam logic [OP_W-1:0] OP_SEED_UPD  = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd10;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd11;
  localparam logic [OP_W-1:0] OP_RD_I      = 5'd12;
  localparam logic [OP_W-1:0] OP_RD_J      = 5'd13;
  localparam logic [OP_W-1:0] OP_WR_I      = 5'd14;
  localparam logic [OP_W-1:0] OP_WR_J      = 5'd15;
  localparam logic [OP_W-1:0] OP_EMIT      = 5'd16;

  // Jump conditions.
  localparam logic [COND_W-1:0] C_NONE     = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NSTART   = 4'd2;
  localparam logic [COND_W-1:0] C_FUNC     = 4'd3;
  localparam logic [COND_W-1:0] C_NKLAST   = 4'd4;
  localparam logic [COND_W-1:0] C_SHORT    = 4'd5;
  localparam logic [COND_W-1:0] C_NDIVLAST = 4'd6;
  localparam logic [COND_W-1:0] C_NILAST   = 4'd7;
  localparam logic [COND_W-1:0] C_OBUSY    = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              short_cnt;
    logic              k_last;
    logic              div_last;
    logic              i_last;
  } dp_flags_t;

endpackage

// ----- rtl/core/its_useq.sv -----
// Microcode sequencer: program ROM, step counter and conditional jumps.
module its_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_busy,
  input  its_pkg::dp_flags_t dp_flags,
  output its_pkg::ctrl_t    ctrl
);
  import its_pkg::*;

  localparam logic [PC_W-1:0] A_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] A_DISP  = 5'd1;
  localparam logic [PC_W-1:0] A_LOAD  = 5'd2;
  localparam logic [PC_W-1:0] A_RD0   = 5'd3;
  localparam logic [PC_W-1:0] A_RD1   = 5'd4;
  localparam logic [PC_W-1:0] A_FL0   = 5'd5;
  localparam logic [PC_W-1:0] A_FL1   = 5'd6;
  localparam logic [PC_W-1:0] A_FL2   = 5'd7;
  localparam logic [PC_W-1:0] A_SH0   = 5'd8;
  localparam logic [PC_W-1:0] A_SH1   = 5'd9;
  localparam logic [PC_W-1:0] A_SH2   = 5'd10;
  localparam logic [PC_W-1:0] A_SH3   = 5'd11;
  localparam logic [PC_W-1:0] A_SH4   = 5'd12;
  localparam logic [PC_W-1:0] A_SH5   = 5'd13;
  localparam logic [PC_W-1:0] A_SH6   = 5'd14;
  localparam logic [PC_W-1:0] A_SH7   = 5'd15;
  localparam logic [PC_W-1:0] A_SH8   = 5'd16;
  localparam logic [PC_W-1:0] A_DONE  = 5'd17;
  localparam logic [PC_W-1:0] A_RET   = 5'd18;
  localparam logic [PC_W-1:0] A_CL0   = 5'd19;
  localparam logic [PC_W-1:0] A_CL1   = 5'd20;
  localparam logic [PC_W-1:0] A_CL2   = 5'd21;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  function automatic ctrl_t mk(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                               input logic [PC_W-1:0] target);
    ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Without a jump the counter moves to the next word.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] a);
    ctrl_t w;
    case (a)
      A_IDLE:  w = mk(OP_WAIT,      C_NSTART,   A_IDLE);
      A_DISP:  w = mk(OP_NOP,       C_FUNC,     A_IDLE);
      A_LOAD:  w = mk(OP_SEED_LD,   C_ALWAYS,   A_DONE);
      A_RD0:   w = mk(OP_RD_POS,    C_NONE,     A_IDLE);
      A_RD1:   w = mk(OP_CAP_ENTRY, C_ALWAYS,   A_DONE);
      A_FL0:   w = mk(OP_CLR_K,     C_NONE,     A_IDLE);
      A_FL1:   w = mk(OP_FILL,      C_NKLAST,   A_FL1);
      A_FL2:   w = mk(OP_NOP,       C_ALWAYS,   A_DONE);
      A_SH0:   w = mk(OP_LD_I,      C_SHORT,    A_DONE);
      A_SH1:   w = mk(OP_MUL,       C_NONE,     A_IDLE);
      A_SH2:   w = mk(OP_SEED_UPD,  C_NONE,     A_IDLE);
      A_SH3:   w = mk(OP_DIV_INIT,  C_NONE,     A_IDLE);
      A_SH4:   w = mk(OP_DIV_STEP,  C_NDIVLAST, A_SH4);
      A_SH5:   w = mk(OP_RD_I,      C_NONE,     A_IDLE);
      A_SH6:   w = mk(OP_RD_J,      C_NONE,     A_IDLE);
      A_SH7:   w = mk(OP_WR_I,      C_NONE,     A_IDLE);
      A_SH8:   w = mk(OP_WR_J,      C_NILAST,   A_SH1);
      A_DONE:  w = mk(OP_EMIT,      C_OBUSY,    A_DONE);
      A_RET:   w = mk(OP_NOP,       C_ALWAYS,   A_IDLE);
      A_CL0:   w = mk(OP_CLR_K,     C_NONE,     A_IDLE);
      A_CL1:   w = mk(OP_FILL,      C_NKLAST,   A_CL1);
      A_CL2:   w = mk(OP_NOP,       C_ALWAYS,   A_IDLE);
      default: w = mk(OP_NOP,       C_ALWAYS,   A_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] func_entry(input logic [FUNC_W-1:0] f);
    logic [PC_W-1:0] a;
    case (f)
      FUNC_LOAD_SEED: a = A_LOAD;
      FUNC_SHUFFLE:   a = A_SH0;
      FUNC_READ:      a = A_RD0;
      FUNC_FILL:      a = A_FL0;
      default:        a = A_IDLE;
    endcase
    return a;
  endfunction

  assign ctrl = ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NSTART:   take = !start;
      C_FUNC:     take = 1'b1;
      C_NKLAST:   take = !dp_flags.k_last;
      C_SHORT:    take = dp_flags.short_cnt;
      C_NDIVLAST: take = !dp_flags.div_last;
      C_NILAST:   take = !dp_flags.i_last;
      C_OBUSY:    take = out_busy;
      default:    take = 1'b0;
    endcase
    if (ctrl.cond == C_FUNC) begin
      pc_next = func_entry(dp_flags.func);
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // Reset enters the clearing program that writes the identity order.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_CL0;
    end else begin
      pc <= pc_next;
    end
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst) pc <= A_CL2)
    else $error("step counter left the program");

endmodule

// ----- rtl/core/its_dpath.sv -----
// Datapath: seed generator, serial remainder unit, index counters and the index table.
module its_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  its_pkg::ctrl_t             ctrl,
  input  logic                       start,
  input  logic [its_pkg::FUNC_W-1:0] in_func,
  input  logic [its_pkg::SEED_W-1:0] in_seed,
  input  logic [its_pkg::POS_W-1:0]  in_pos,
  input  logic [its_pkg::CNT_W-1:0]  count,
  output its_pkg::dp_flags_t         dp_flags,
  output logic [its_pkg::ENT_W-1:0]  res_entry,
  output logic [its_pkg::SEED_W-1:0] seed
);
  import its_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int PW = (AW + 1 > POS_W) ? AW + 1 : POS_W;

  logic [AW-1:0]     mem [TABLE_DEPTH];
  logic [AW-1:0]     rdata;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     wdata;
  logic              we;

  logic [FUNC_W-1:0] func_q;
  logic [SEED_W-1:0] seed_in_q;
  logic [POS_W-1:0]  pos_q;
  logic [SEED_W-1:0] prod;
  logic [SEED_W-1:0] quo;
  logic [AW-1:0]     rem;
  logic [4:0]        bitcnt;
  logic [AW-1:0]     i;
  logic [AW-1:0]     j;
  logic [AW-1:0]     k;
  logic [AW-1:0]     vi;

  logic [NW-1:0]     count_ext;
  logic [NW-1:0]     n_sat;
  logic [NW-1:0]     n_less;
  logic [PW-1:0]     pos_ext;
  logic              pos_ok;
  logic [AW:0]       divisor;
  logic [AW:0]       trial;
  logic [AW:0]       diff;

  assign count_ext = NW'(count);
  assign n_sat     = (count_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : count_ext;
  assign n_less    = n_sat - NW'(1);
  assign pos_ext   = PW'(pos_q);
  assign pos_ok    = pos_ext < PW'(TABLE_DEPTH);

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign divisor = {1'b0, i} + (AW + 1)'(1);
  assign trial   = {rem, quo[SEED_W-1]};
  assign diff    = trial - divisor;

  assign dp_flags.func      = func_q;
  assign dp_flags.short_cnt = count < CNT_W'(2);
  assign dp_flags.k_last    = k == AW'(TABLE_DEPTH - 1);
  assign dp_flags.div_last  = bitcnt == 5'd0;
  assign dp_flags.i_last    = i == AW'(1);

  always_comb begin
    raddr = i;
    waddr = i;
    wdata = rdata;
    we    = 1'b0;
    unique case (ctrl.op)
      OP_RD_POS: raddr = pos_ext[AW-1:0];
      OP_RD_I:   raddr = i;
      OP_RD_J:   raddr = j;
      OP_FILL: begin
        we    = 1'b1;
        waddr = k;
        wdata = k;
      end
      OP_WR_I: begin
        we    = 1'b1;
        waddr = i;
        wdata = rdata;
      end
      OP_WR_J: begin
        we    = 1'b1;
        waddr = j;
        wdata = vi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (ctrl.op == OP_SEED_LD) begin
      seed <= seed_in_q;
    end else if (ctrl.op == OP_SEED_UPD) begin
      seed <= prod + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      func_q    <= in_func;
      seed_in_q <= in_seed;
      pos_q     <= in_pos;
      res_entry <= '0;
    end
    case (ctrl.op)
      OP_CAP_ENTRY: res_entry <= pos_ok ? ENT_W'(rdata) : '0;
      OP_CLR_K:     k <= '0;
      OP_FILL:      k <= k + AW'(1);
      OP_LD_I:      i <= n_less[AW-1:0];
      OP_MUL:       prod <= seed * LCG_MUL;
      OP_DIV_INIT: begin
        rem    <= '0;
        quo    <= seed;
        bitcnt <= 5'd31;
      end
      OP_DIV_STEP: begin
        rem    <= (trial >= divisor) ? diff[AW-1:0] : trial[AW-1:0];
        quo    <= {quo[SEED_W-2:0], 1'b0};
        bitcnt <= bitcnt - 5'd1;
      end
      OP_RD_I:      j <= rem;
      OP_RD_J:      vi <= rdata;
      OP_WR_J:      i <= i - AW'(1);
      default: ;
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |=> ({1'b0, rem} < divisor))
    else $error("remainder not below divisor");

  a_j_not_above_i: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_RD_I) |=> (j <= i))
    else $error("swap partner above current entry");

endmodule

// ----- rtl/core/index_table_shuffler_top.sv -----
// Top level of the index table shuffler: stream ports, count register and result register.
//
//   channel   direction  fields (low bit first)
//   s_*       in         func[1:0], seed_value[33:2], position[43:34]
//   m_*       out        entry_value[9:0], seed_now[41:10]
//   cfg_*     in         count_in_use[10:0]
//
// Load seed, read entry, fill identity and a shuffle of n entries each run as a microcode
// program; a shuffle of fewer than 2 entries goes straight to the result, and each swap
// waits for the 32-step serial remainder unit. After reset a clearing pass writes the
// identity order while s_tready stays low. One command is in work at a time; a finished
// result waits in the output register and the next command is taken while it waits.
module index_table_shuffler_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [47:0]               s_tdata,   // func, seed_value, position, zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [47:0]               m_tdata,   // entry_value, seed_now, zero pad
  input  logic                      cfg_we,
  input  logic [its_pkg::CNT_W-1:0] cfg_wdata
);
  import its_pkg::*;

  localparam int OUT_PAD = 48 - ENT_W - SEED_W;

  logic              start;
  logic              out_busy;
  logic              load;
  logic [CNT_W-1:0]  count;
  ctrl_t             ctrl;
  dp_flags_t         dp_flags;
  logic [ENT_W-1:0]  res_entry;
  logic [SEED_W-1:0] seed;

  assign s_tready = ctrl.op == OP_WAIT;
  assign start    = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;
  assign load     = (ctrl.op == OP_EMIT) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_we) begin
      count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {OUT_PAD'(0), seed, res_entry};
    end
  end

  its_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_busy (out_busy),
    .dp_flags (dp_flags),
    .ctrl     (ctrl)
  );

  its_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .start     (start),
    .in_func   (s_tdata[1:0]),
    .in_seed   (s_tdata[33:2]),
    .in_pos    (s_tdata[43:34]),
    .count     (count),
    .dp_flags  (dp_flags),
    .res_entry (res_entry),
    .seed      (seed)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready)
    else $error("second transfer taken while a command is in work");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten before its transfer");

endmodule
